/* rtl/core/tat_pkg.sv */
// Package for the thermistor ADC to temperature converter.
// Holds shared widths, register indexes, reset values and the config and item types.
// No dependencies.
`default_nettype none
package tat_pkg;

  localparam int ADC_BITS_DEF = 16;
  localparam int CODE_W       = 16;
  localparam int TEMP_W       = 16;
  localparam int CFG_W        = 20;
  localparam int CFG_IDX_W    = 3;
  localparam int DIVN_W       = 56;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_RATIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_TEMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KOFFSET    = 3'd5;

  localparam logic [7:0]  GAIN_RST    = 8'd1;
  localparam logic [16:0] RATIO_RST   = 17'd32768;
  localparam logic [19:0] SRES_RST    = 20'd10000;
  localparam logic [15:0] BETA_RST    = 16'd3950;
  localparam logic [15:0] T0_RST      = 16'd29815;
  localparam logic [15:0] KOFF_RST    = 16'd27315;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;

  typedef struct packed {
    logic [7:0]  gain;
    logic [16:0] ratio;
    logic [19:0] sres;
    logic [15:0] beta;
    logic [15:0] t0;
    logic [15:0] koff;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              ok;
  } item_t;

  typedef struct packed {
    logic              busy;
    logic [TEMP_W-1:0] last_temp;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/core/tat_if.sv */
// Stream interfaces for the converter: raw ADC codes in, temperatures out.
// Depends on tat_pkg.
`default_nettype none
interface tat_adc_if;
  logic                       valid;
  logic                       ready;
  logic [tat_pkg::CODE_W-1:0] adc_code;
  modport source (output valid, adc_code, input ready);
  modport sink (input valid, adc_code, output ready);
endinterface

interface tat_temp_if;
  logic                              valid;
  logic                              ready;
  logic signed [tat_pkg::TEMP_W-1:0] temperature_centi;
  logic                              temperature_valid;
  modport source (output valid, temperature_centi, temperature_valid, input ready);
  modport sink (input valid, temperature_centi, temperature_valid, output ready);
endinterface
`default_nettype wire

/* rtl/core/tat_front.sv */
// Front end: accepts ADC codes, flags rejected ones, queues up to two items.
// Depends on tat_pkg and tat_if.
`default_nettype none
module tat_front #(
  parameter int ADC_BITS = tat_pkg::ADC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tat_pkg::cfg_t  cfg,
  tat_adc_if.sink             adc_in,
  output logic                item_valid,
  input  wire logic           item_ready,
  output tat_pkg::item_t      item
);
  localparam logic [24:0] FULL = 25'((64'd1 << ADC_BITS) - 64'd1);

  tat_pkg::item_t q [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           push, pop;
  tat_pkg::item_t incoming;

  always_comb begin
    incoming.code = adc_in.adc_code;
    incoming.ok   = (adc_in.adc_code != '0) && ({9'b0, adc_in.adc_code} < FULL) &&
                    (cfg.sres != '0) && (cfg.t0 != '0);
  end

  assign adc_in.ready = (cnt != 2'd2);
  assign push         = adc_in.valid && adc_in.ready;
  assign item_valid   = (cnt != 2'd0);
  assign pop          = item_valid && item_ready;
  assign item         = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tat_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module tat_div #(
  parameter int NW  = 56,
  parameter int DVW = 42
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [NW-1:0]  numer,
  input  wire logic [DVW-1:0] denom,
  output logic                done,
  output logic [NW-1:0]       quot
);
  localparam int CW = $clog2(NW + 1);

  logic [DVW:0]   rem;
  logic [DVW-1:0] den;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DVW:0]   rem_sh;
  logic           take;

  assign rem_sh = {rem[DVW-1:0], quot[NW-1]};
  assign take   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      den  <= denom;
      quot <= numer;
    end else if (busy) begin
      rem  <= take ? rem_sh - {1'b0, den} : rem_sh;
      quot <= {quot[NW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tat_log2.sv */
// Log2 in Q16: normalize one bit a cycle, then sixteen squarings of a Q30 mantissa.
// Depends on nothing.
`default_nettype none
module tat_log2 #(
  parameter int LW = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [LW-1:0]               x,
  output logic                             done,
  output logic [$clog2(LW)+16-1:0]         result
);
  localparam int KW = $clog2(LW);
  localparam int XW = LW + 31;
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_SQR  = 2'd3;

  logic [1:0]    st;
  logic [XW-1:0] xn;
  logic [KW-1:0] k;
  logic [30:0]   m;
  logic [61:0]   sq;
  logic [15:0]   frac;
  logic [3:0]    cnt;
  logic [31:0]   sqs;

  assign sqs    = sq[61:30];
  assign result = {k, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        L_IDLE: begin
          if (start) st <= L_NORM;
        end
        L_NORM: begin
          if (xn[XW-1] || k == '0) st <= L_MUL;
        end
        L_MUL: st <= L_SQR;
        L_SQR: begin
          if (cnt == 4'd15) begin
            st   <= L_IDLE;
            done <= 1'b1;
          end else begin
            st <= L_MUL;
          end
        end
        default: st <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == L_IDLE && start) begin
      xn   <= {x, 31'b0};
      k    <= KW'(LW - 1);
      frac <= '0;
      cnt  <= '0;
    end else if (st == L_NORM) begin
      if (!xn[XW-1] && k != '0) begin
        xn <= xn << 1;
        k  <= k - 1'b1;
      end else begin
        m <= xn[XW-1 -: 31];
      end
    end else if (st == L_MUL) begin
      sq <= {31'b0, m} * {31'b0, m};
    end else if (st == L_SQR) begin
      cnt <= cnt + 1'b1;
      if (sqs[31]) begin
        m    <= sqs[31:1];
        frac <= {frac[14:0], 1'b1};
      end else begin
        m    <= sqs[30:0];
        frac <= {frac[14:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tat_back.sv */
// Back end: sequences resistance ratio, log, beta equation and saturation per item.
// Depends on tat_pkg, tat_if, tat_div and tat_log2.
`default_nettype none
module tat_back #(
  parameter int ADC_BITS = tat_pkg::ADC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tat_pkg::cfg_t  cfg,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire tat_pkg::item_t item,
  tat_temp_if.source          temp_out,
  output tat_pkg::stat_t      stat
);
  localparam int CW   = (ADC_BITS > 16 ? ADC_BITS : 16) + 1;
  localparam int PW   = CW - 1 + 17;
  localparam int SW   = PW + 2;
  localparam int LW   = ADC_BITS + 15;
  localparam int LGW  = $clog2(LW) + 16;
  localparam int DDW  = (LGW + 19 > 40 ? LGW + 19 : 40) + 1;
  localparam int NNW  = tat_pkg::DIVN_W;
  localparam logic signed [CW-1:0] HALF = CW'(((64'd1 << ADC_BITS) - 64'd1) >> 1);
  localparam logic signed [SW-1:0] QQ   = SW'((((64'd1 << ADC_BITS) - 64'd1) >> 2) << 16);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_MULC  = 4'd1;
  localparam logic [3:0] B_DIVC  = 4'd2;
  localparam logic [3:0] B_WDIVC = 4'd3;
  localparam logic [3:0] B_LOGN  = 4'd4;
  localparam logic [3:0] B_WLOGN = 4'd5;
  localparam logic [3:0] B_LOGD  = 4'd6;
  localparam logic [3:0] B_WLOGD = 4'd7;
  localparam logic [3:0] B_LNM   = 4'd8;
  localparam logic [3:0] B_LQ    = 4'd9;
  localparam logic [3:0] B_MULD  = 4'd10;
  localparam logic [3:0] B_DSUM  = 4'd11;
  localparam logic [3:0] B_DIVT  = 4'd12;
  localparam logic [3:0] B_WDIVT = 4'd13;
  localparam logic [3:0] B_SAT   = 4'd14;
  localparam logic [3:0] B_RES   = 4'd15;

  logic [3:0]               st;
  logic signed [CW-1:0]     cd;
  logic                     csgn;
  logic [PW-1:0]            prod;
  logic [22:0]              b100;
  logic [LW-1:0]            numr, denr;
  logic [LGW-1:0]           lg_n;
  logic signed [LGW:0]      ldiff;
  logic                     neg;
  logic [LGW+29:0]          lnp;
  logic signed [LGW+1:0]    lq;
  logic signed [LGW+18:0]   lt;
  logic [38:0]              nprod;
  logic [DDW-1:0]           dreg;
  logic [NNW-1:0]           tnum;
  logic [NNW-1:0]           tq;
  logic signed [15:0]       res_temp;
  logic                     res_valid;
  logic [15:0]              last_temp;
  logic                     ovalid;

  logic                     div_start, div_done;
  logic [NNW-1:0]           div_numer, div_quot;
  logic [DDW-1:0]           div_denom;
  logic                     log_start, log_done;
  logic [LW-1:0]            log_x;
  logic [LGW-1:0]           log_res;

  logic signed [CW-1:0]     diff_c;
  logic signed [SW-1:0]     c_s, numv, denv;
  logic [LGW+30:0]          lm_sum;
  logic [LGW:0]             lm;
  logic signed [DDW-1:0]    dv;
  logic signed [NNW+1:0]    tc;
  logic [7:0]               gain_eff;

  assign diff_c   = $signed({{(CW-16){1'b0}}, item.code}) - HALF;
  assign c_s      = csgn ? -$signed({2'b0, div_quot[PW-1:0]}) : $signed({2'b0, div_quot[PW-1:0]});
  assign numv     = QQ + c_s;
  assign denv     = QQ - c_s;
  assign lm_sum   = {1'b0, lnp} + (LGW+31)'(64'd1 << 29);
  assign lm       = lm_sum[LGW+30:30];
  assign dv       = DDW'($signed({1'b0, b100, 16'b0})) + DDW'(lt);
  assign tc       = $signed({2'b0, tq}) - $signed((NNW+2)'(cfg.koff));
  assign gain_eff = (cfg.gain == '0) ? 8'd1 : cfg.gain;

  assign div_start = (st == B_DIVC) || (st == B_DIVT);
  assign div_numer = (st == B_DIVC) ? NNW'(prod) : tnum;
  assign div_denom = (st == B_DIVC) ? DDW'(gain_eff) : dreg;
  assign log_start = (st == B_LOGN) || (st == B_LOGD);
  assign log_x     = (st == B_LOGN) ? numr : denr;

  assign item_ready                  = (st == B_IDLE);
  assign temp_out.valid              = ovalid;
  assign stat.busy                   = (st != B_IDLE);
  assign stat.last_temp              = last_temp;

  tat_div #(.NW(NNW), .DVW(DDW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_numer), .denom(div_denom),
    .done(div_done), .quot(div_quot)
  );

  tat_log2 #(.LW(LW)) u_log (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x), .done(log_done), .result(log_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      ovalid    <= 1'b0;
      last_temp <= '0;
    end else begin
      if (ovalid && temp_out.ready) ovalid <= 1'b0;
      unique case (st)
        B_IDLE: begin
          if (item_valid) begin
            st <= item.ok ? B_MULC : B_RES;
          end
        end
        B_MULC:  st <= B_DIVC;
        B_DIVC:  st <= B_WDIVC;
        B_WDIVC: begin
          if (div_done) st <= (numv > 0 && denv > 0) ? B_LOGN : B_RES;
        end
        B_LOGN:  st <= B_WLOGN;
        B_WLOGN: begin
          if (log_done) st <= B_LOGD;
        end
        B_LOGD:  st <= B_WLOGD;
        B_WLOGD: begin
          if (log_done) st <= B_LNM;
        end
        B_LNM:   st <= B_LQ;
        B_LQ:    st <= B_MULD;
        B_MULD:  st <= B_DSUM;
        B_DSUM:  st <= (dv > 0) ? B_DIVT : B_RES;
        B_DIVT:  st <= B_WDIVT;
        B_WDIVT: begin
          if (div_done) st <= B_SAT;
        end
        B_SAT:   st <= B_RES;
        B_RES: begin
          if (!ovalid || temp_out.ready) begin
            ovalid <= 1'b1;
            if (res_valid) last_temp <= res_temp;
            st <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: begin
        res_valid <= 1'b0;
        cd        <= diff_c;
        b100      <= 23'(cfg.beta * 7'd100);
      end
      B_MULC: begin
        csgn <= cd < 0;
        prod <= PW'(cfg.ratio * (CW-1)'(cd < 0 ? -cd : cd));
      end
      B_WDIVC: begin
        numr <= numv[LW-1:0];
        denr <= denv[LW-1:0];
      end
      B_WLOGN: begin
        if (log_done) lg_n <= log_res;
      end
      B_WLOGD: begin
        if (log_done) ldiff <= $signed({1'b0, lg_n}) - $signed({1'b0, log_res});
      end
      B_LNM: begin
        neg <= ldiff < 0;
        lnp <= LGW'(ldiff < 0 ? -ldiff : ldiff) * tat_pkg::LN2_Q30;
      end
      B_LQ: begin
        lq <= neg ? -$signed({1'b0, lm}) : $signed({1'b0, lm});
      end
      B_MULD: begin
        lt    <= lq * $signed({1'b0, cfg.t0});
        nprod <= b100 * cfg.t0;
      end
      B_DSUM: begin
        dreg <= dv;
        tnum <= NNW'({nprod, 16'b0}) + NNW'(dv[DDW-1:1]);
      end
      B_WDIVT: begin
        if (div_done) tq <= div_quot;
      end
      B_SAT: begin
        res_valid <= 1'b1;
        if (tc > 32767) res_temp <= 16'sh7fff;
        else if (tc < -32768) res_temp <= 16'sh8000;
        else res_temp <= tc[15:0];
      end
      B_RES: begin
        if (!ovalid || temp_out.ready) begin
          temp_out.temperature_valid <= res_valid;
          temp_out.temperature_centi <= res_valid ? res_temp : last_temp;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/thermistor_adc_to_temperature.sv */
// A rejected code goes from idle straight to the result state. A converted code is
// divided for the resistance ratio, takes two log passes, then the beta equation, a
// second division and saturation. One item is converted at a time, as the bit-serial
// divider and log2 are shared between the steps of each item.
// A two-item queue takes input while a result waits. Reset (rst, synchronous)
// restores the register defaults, clears last temperature and empties all stages.
`default_nettype none
module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = tat_pkg::ADC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tat_pkg::CFG_W-1:0]     cfg_data,
  tat_adc_if.sink                            adc_in,
  tat_temp_if.source                         temp_out
);
  tat_pkg::cfg_t  cfg;
  tat_pkg::item_t item;
  tat_pkg::stat_t stat;
  logic           item_valid, item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain  <= tat_pkg::GAIN_RST;
      cfg.ratio <= tat_pkg::RATIO_RST;
      cfg.sres  <= tat_pkg::SRES_RST;
      cfg.beta  <= tat_pkg::BETA_RST;
      cfg.t0    <= tat_pkg::T0_RST;
      cfg.koff  <= tat_pkg::KOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tat_pkg::REG_ADC_GAIN:   cfg.gain  <= cfg_data[7:0];
        tat_pkg::REG_REF_RATIO:  cfg.ratio <= cfg_data[16:0];
        tat_pkg::REG_SERIES_RES: cfg.sres  <= cfg_data[19:0];
        tat_pkg::REG_BETA:       cfg.beta  <= cfg_data[15:0];
        tat_pkg::REG_NOM_TEMP:   cfg.t0    <= cfg_data[15:0];
        tat_pkg::REG_KOFFSET:    cfg.koff  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  tat_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .adc_in(adc_in),
    .item_valid(item_valid), .item_ready(item_ready), .item(item)
  );

  tat_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .item_valid(item_valid), .item_ready(item_ready),
    .item(item), .temp_out(temp_out), .stat(stat)
  );

`ifndef SYNTHESIS
  a_out_matches_last: assert property (@(posedge clk) disable iff (rst)
    temp_out.valid |-> temp_out.temperature_centi == stat.last_temp)
    else $error("delivered temperature differs from held temperature");
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(temp_out.valid) |-> $past(stat.busy))
    else $error("result appeared without back end activity");
`endif
endmodule
`default_nettype wire

/* bench/thermistor_adc_to_temperature_tb.sv */
// Testbench for thermistor_adc_to_temperature: drives ADC codes over several register
// settings and checks each temperature against a bit-exact beta-equation predictor.
// Depends on tat_pkg, tat_adc_if, tat_temp_if and the converter RTL.
`timescale 1ns / 1ps
module thermistor_adc_to_temperature_tb;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tat_pkg::CFG_W-1:0] cfg_data;

  tat_adc_if adc_ch();
  tat_temp_if temp_ch();

  thermistor_adc_to_temperature i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .adc_in(adc_ch),
    .temp_out(temp_ch)
  );

  typedef struct packed {
    logic signed [tat_pkg::TEMP_W-1:0] temp;
    logic ok;
  } temp_res_t;

  tat_pkg::cfg_t regs;
  logic [tat_pkg::TEMP_W-1:0] held_temp;
  temp_res_t temp_q[$];
  int errors;
  int burst_left;
  int stall_mode;
  int stall_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint log2_fix(longint x);
    int k;
    longint m;
    longint frac;
    k = 63;
    frac = 0;
    while (k > 0 && x[k] == 1'b0) k--;
    if (k <= 30) m = x << (30 - k);
    else m = x >> (k - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >>> 30;
      frac = frac << 1;
      if (m >= (64'sd1 << 31)) begin
        m = m >>> 1;
        frac = frac | 1;
      end
    end
    return longint'(k) * 65536 + frac;
  endfunction

  function automatic temp_res_t convert_code(logic [tat_pkg::CODE_W-1:0] code);
    longint full, half, qtr, gain, c, num, den, diff, mag, lm, lq, b100, t0, d, n, tk, tc;
    logic ok;
    temp_res_t r;
    full = (64'sd1 << tat_pkg::ADC_BITS_DEF) - 1;
    half = full >>> 1;
    qtr = (full >>> 2) * 65536;
    gain = (regs.gain == 0) ? 1 : longint'(regs.gain);
    ok = 1'b0;
    tc = 0;
    if (code != 0 && longint'(code) < full && regs.sres != 0 && regs.t0 != 0) begin
      c = (longint'(regs.ratio) * (longint'(code) - half)) / gain;
      num = qtr + c;
      den = qtr - c;
      if (num > 0 && den > 0) begin
        diff = log2_fix(num) - log2_fix(den);
        mag = (diff < 0) ? -diff : diff;
        lm = (mag * 64'sd744261118 + (64'sd1 << 29)) >>> 30;
        lq = (diff < 0) ? -lm : lm;
        b100 = 100 * longint'(regs.beta);
        t0 = longint'(regs.t0);
        d = b100 * 65536 + lq * t0;
        if (d > 0) begin
          n = b100 * t0 * 65536;
          tk = (n + d / 2) / d;
          tc = tk - longint'(regs.koff);
          if (tc > 32767) tc = 32767;
          if (tc < -32768) tc = -32768;
          ok = 1'b1;
        end
      end
    end
    if (ok) held_temp = tc[15:0];
    r.temp = held_temp;
    r.ok = ok;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      temp_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_cnt <= $urandom_range(20, 300);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0: temp_ch.ready <= 1'b1;
        1: temp_ch.ready <= ($urandom_range(0, 3) != 0);
        2: temp_ch.ready <= stall_cnt[2];
        default: temp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    temp_res_t want;
    if (!rst && temp_ch.valid && temp_ch.ready) begin
      if (temp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: temp=%0d ok=%0b",
                   temp_ch.temperature_centi, temp_ch.temperature_valid);
      end else begin
        want = temp_q.pop_front();
        if (temp_ch.temperature_centi !== want.temp ||
            temp_ch.temperature_valid !== want.ok) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: temp exp %0d got %0d, ok exp %0b got %0b",
                     want.temp, temp_ch.temperature_centi, want.ok,
                     temp_ch.temperature_valid);
        end
      end
    end
  end

  task automatic send_code(logic [tat_pkg::CODE_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        adc_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    adc_ch.valid <= 1'b1;
    adc_ch.adc_code <= code;
    do @(posedge clk); while (!adc_ch.ready);
    temp_q.push_back(convert_code(code));
  endtask

  task automatic drain();
    adc_ch.valid <= 1'b0;
    burst_left = 0;
    while (temp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(tat_pkg::cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= tat_pkg::REG_ADC_GAIN;   cfg_data <= tat_pkg::CFG_W'(c.gain);
    @(posedge clk);
    cfg_index <= tat_pkg::REG_REF_RATIO;  cfg_data <= tat_pkg::CFG_W'(c.ratio);
    @(posedge clk);
    cfg_index <= tat_pkg::REG_SERIES_RES; cfg_data <= tat_pkg::CFG_W'(c.sres);
    @(posedge clk);
    cfg_index <= tat_pkg::REG_BETA;       cfg_data <= tat_pkg::CFG_W'(c.beta);
    @(posedge clk);
    cfg_index <= tat_pkg::REG_NOM_TEMP;   cfg_data <= tat_pkg::CFG_W'(c.t0);
    @(posedge clk);
    cfg_index <= tat_pkg::REG_KOFFSET;    cfg_data <= tat_pkg::CFG_W'(c.koff);
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  function automatic tat_pkg::cfg_t make_cfg(int g, int ra, int s, int b, int t, int k);
    tat_pkg::cfg_t c;
    c.gain = 8'(g); c.ratio = 17'(ra); c.sres = 20'(s);
    c.beta = 16'(b); c.t0 = 16'(t); c.koff = 16'(k);
    return c;
  endfunction

  task automatic test_default_codes();
    logic [tat_pkg::CODE_W-1:0] codes[12] = '{16'd0, 16'd65535, 16'd1, 16'd65534,
      16'd32767, 16'd32768, 16'd16384, 16'd49151, 16'd40000, 16'd20000, 16'h5555,
      16'hAAAA};
    foreach (codes[i]) send_code(codes[i]);
    drain();
  endtask

  task automatic test_register_extremes();
    tat_pkg::cfg_t sets[8];
    logic [tat_pkg::CODE_W-1:0] codes[4] = '{16'd1, 16'd65534, 16'd30000, 16'd36000};
    sets[0] = make_cfg(128, 65536, 1048575, 65535, 65535, 65535);
    sets[1] = make_cfg(0, 32768, 10000, 3950, 29815, 27315);
    sets[2] = make_cfg(1, 0, 1, 1, 1, 0);
    sets[3] = make_cfg(1, 65536, 0, 3950, 29815, 27315);
    sets[4] = make_cfg(1, 65536, 10000, 3950, 0, 27315);
    sets[5] = make_cfg(1, 65536, 10000, 1, 65535, 0);
    sets[6] = make_cfg(255, 131071, 10000, 65535, 1, 65535);
    sets[7] = make_cfg(2, 65536, 4700, 100, 29815, 0);
    foreach (sets[s]) begin
      write_regs(sets[s]);
      foreach (codes[i]) send_code(codes[i]);
      drain();
    end
  endtask

  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic test_random_codes();
    tat_pkg::cfg_t c;
    logic [tat_pkg::CODE_W-1:0] code;
    for (int p = 0; p < 8; p++) begin
      c = make_cfg(pick(1, 128), pick(0, 65536), pick(1, 1048575), pick(1, 65535),
                   pick(1, 65535), pick(0, 65535));
      if (p == 0) c = make_cfg(1, 32768, 10000, 3950, 29815, 27315);
      write_regs(c);
      for (int i = 0; i < 90; i++) begin
        case ($urandom_range(0, 19))
          0: code = 16'd0;
          1: code = 16'hFFFF;
          2, 3, 4: code = 16'(32767 + int'($urandom_range(0, 2048)) - 1024);
          default: code = 16'($urandom);
        endcase
        send_code(code);
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    adc_ch.valid = 1'b0;
    adc_ch.adc_code = '0;
    temp_ch.ready = 1'b0;
    errors = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_cnt = 0;
    held_temp = '0;
    regs = make_cfg(1, 32768, 10000, 3950, 29815, 27315);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_codes();
    test_register_extremes();
    test_random_codes();
    repeat (300) @(posedge clk);
    if (errors == 0 && temp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
